### src/fcr_pkg.sv
package fcr_pkg;

  // Delay line geometry
  localparam int MAX_DELAY = 16384;
  localparam int AW        = $clog2(MAX_DELAY);
  localparam int DLY_W     = 15;
  // Count width: holds MAX_DELAY itself and any delay register value
  localparam int CW        = ((AW + 1) > DLY_W) ? (AW + 1) : DLY_W;

  // Register map (byte addresses)
  localparam int PAW = 4;
  localparam logic [PAW-1:0] REG_DELAY = 4'h0;
  localparam logic [PAW-1:0] REG_DRY   = 4'h4;
  localparam logic [PAW-1:0] REG_WET   = 4'h8;

  // Reset values
  localparam logic [DLY_W-1:0] DELAY_RST = 15'd1;
  localparam logic [15:0]      DRY_RST   = 16'd4096;
  localparam logic [15:0]      WET_RST   = 16'd2048;

  typedef struct packed {
    logic [DLY_W-1:0]   delay_samples;
    logic signed [15:0] src_gain;
    logic signed [15:0] fb_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               clip_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               clipped;
    logic               clipped_seen;
  } out_item_t;

  // Item held in the compute stage
  typedef struct packed {
    logic signed [15:0] sample;
    logic               clip_start;
    logic               pass;
    logic               use_last;
    logic [AW-1:0]      wptr;
  } stage_t;

endpackage

### src/fcr_cfg.sv
module fcr_cfg import fcr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output cfg_t           cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr)
        REG_DELAY: cfg_d.delay_samples = pwdata[DLY_W-1:0];
        REG_DRY:   cfg_d.src_gain      = pwdata[15:0];
        REG_WET:   cfg_d.fb_gain       = pwdata[15:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_samples <= DELAY_RST;
      cfg_q.src_gain      <= DRY_RST;
      cfg_q.fb_gain       <= WET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr)
      REG_DELAY: prdata = {{(32-DLY_W){1'b0}}, cfg_q.delay_samples};
      REG_DRY:   prdata = {16'd0, cfg_q.src_gain};
      REG_WET:   prdata = {16'd0, cfg_q.fb_gain};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/fcr_delay_ram.sv
module fcr_delay_ram import fcr_pkg::*; (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [MAX_DELAY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds while no new read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### src/fcr_mix.sv
module fcr_mix import fcr_pkg::*; (
  input  stage_t             stage_i,
  input  logic signed [15:0] past_i,
  input  logic signed [15:0] src_gain_i,
  input  logic signed [15:0] fb_gain_i,
  input  logic               sticky_i,
  output out_item_t          result_o
);

  localparam logic signed [20:0] SAT_HI = 21'sd32767;
  localparam logic signed [20:0] SAT_LO = -21'sd32768;

  // Q3.12 scale with truncation toward zero
  function automatic logic signed [19:0] trunc12(input logic signed [31:0] p);
    logic signed [31:0] q;
    q = p >>> 12;
    if (p[31] && (p[11:0] != 12'd0)) begin
      q = q + 32'sd1;
    end
    return q[19:0];
  endfunction

  logic signed [31:0] prod_dry, prod_wet;
  logic signed [19:0] pd, pw;
  logic signed [20:0] sum;
  logic               sticky_base;

  assign prod_dry = stage_i.sample * src_gain_i;
  assign prod_wet = past_i * fb_gain_i;
  assign pd       = trunc12(prod_dry);
  assign pw       = trunc12(prod_wet);
  assign sum      = {pd[19], pd} + {pw[19], pw};

  assign sticky_base = stage_i.clip_start ? 1'b0 : sticky_i;

  // Saturate, or pass the sample through while the line fills
  always_comb begin
    result_o.sample_out = stage_i.sample;
    result_o.clipped    = 1'b0;
    if (!stage_i.pass) begin
      if (sum > SAT_HI) begin
        result_o.sample_out = 16'sh7fff;
        result_o.clipped    = 1'b1;
      end else if (sum < SAT_LO) begin
        result_o.sample_out = -16'sh8000;
        result_o.clipped    = 1'b1;
      end else begin
        result_o.sample_out = sum[15:0];
      end
    end
    result_o.clipped_seen = sticky_base | result_o.clipped;
  end

endmodule

### src/feedback_comb_reverb.sv
// Feedback comb filter over a stream of signed 16-bit samples.
// Input channel: in_valid_i / in_stall_o carry one sample item with a
// clip_start flag; an item is taken on a clock edge with valid high and
// stall low. Output channel: out_valid_o / out_stall_i carry one result item
// (saturated sample, per-item clipped flag, sticky clipped_seen flag).
// Gains and delay are set over the APB port (delay at 0x0, dry at 0x4,
// wet at 0x8); the user must do so only while idle, unenforced by the block.
// Items are registered in the compute stage, results in the output register.
// Throughput: one item per cycle unless the receiver stalls. The read port
// of the delay RAM is used at input acceptance and its write port when the
// compute stage retires; a delay of one is served from the last-output
// register instead of the RAM. When the receiver stalls, the output register
// holds, the compute stage can take one more item, and then in_stall_o rises.
// Reset clears the write pointer, fill count, sticky flag and handshake
// state and restores the register defaults (delay 1, dry 1.0, wet 0.5).
// The delay RAM is not cleared: only entries written in the current clip
// are read.
module feedback_comb_reverb import fcr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  in_item_t       in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output out_item_t      out_item_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  cfg_t               cfg;
  logic [CW-1:0]      dly_raw, dly_eff;
  logic [CW-1:0]      fill_q, fill_d, fill_cur;
  logic [AW-1:0]      wp_q, wp_d;
  logic [CW-1:0]      wp_ext, rd_full;
  logic [AW-1:0]      raddr;
  logic               s1_v_q, s1_v_d;
  stage_t             s1_q;
  logic               out_v_q, out_v_d;
  out_item_t          out_q, result;
  logic               sticky_q;
  logic signed [15:0] last_y_q;
  logic [15:0]        ram_rdata;
  logic signed [15:0] past;
  logic               adv, in_acc, retire;

  fcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake control
  assign adv        = ~out_v_q | ~out_stall_i;
  assign retire     = s1_v_q & adv;
  assign in_stall_o = s1_v_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_v_d     = in_acc | (s1_v_q & ~adv);
  assign out_v_d    = adv ? s1_v_q : out_v_q;

  // Effective delay: zero acts as one, clamped to the line length
  assign dly_raw = CW'(cfg.delay_samples);
  always_comb begin
    dly_eff = dly_raw;
    if (dly_raw == '0) begin
      dly_eff = CW'(1);
    end else if (dly_raw > CW'(MAX_DELAY)) begin
      dly_eff = CW'(MAX_DELAY);
    end
  end

  // Fill count and write pointer, updated at acceptance
  assign fill_cur = in_item_i.clip_start ? '0 : fill_q;
  assign fill_d   = (fill_cur == CW'(MAX_DELAY)) ? fill_cur : fill_cur + CW'(1);
  assign wp_d     = (wp_q == AW'(MAX_DELAY - 1)) ? '0 : wp_q + AW'(1);

  // Read address of the delayed output
  assign wp_ext  = CW'(wp_q);
  assign rd_full = (wp_ext >= dly_eff) ? wp_ext - dly_eff
                                       : wp_ext + CW'(MAX_DELAY) - dly_eff;
  assign raddr   = rd_full[AW-1:0];

  fcr_delay_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_q.wptr),
    .wdata_i (result.sample_out),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Previous output is not in the RAM yet for a delay of one
  assign past = s1_q.use_last ? last_y_q : ram_rdata;

  fcr_mix u_mix (
    .stage_i    (s1_q),
    .past_i     (past),
    .src_gain_i (cfg.src_gain),
    .fb_gain_i  (cfg.fb_gain),
    .sticky_i   (sticky_q),
    .result_o   (result)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      fill_q   <= '0;
      wp_q     <= '0;
      sticky_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      if (in_acc) begin
        fill_q <= fill_d;
        wp_q   <= wp_d;
      end
      if (retire) begin
        sticky_q <= result.clipped_seen;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.sample     <= in_item_i.sample_in;
      s1_q.clip_start <= in_item_i.clip_start;
      s1_q.pass       <= fill_cur < dly_eff;
      s1_q.use_last   <= dly_eff == CW'(1);
      s1_q.wptr       <= wp_q;
    end
    if (retire) begin
      out_q    <= result;
      last_y_q <= result.sample_out;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule
